// ----- rtl/core/envelope_transient_shaper_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Envelope transient shaper: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_TRANSIENT_SHAPER_UNIT_MACROS_SVH
`define ENVELOPE_TRANSIENT_SHAPER_UNIT_MACROS_SVH

// same-cycle implication
`define ETSU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETSU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/etsu_pkg.sv -----
// ----------------------------------------------------------------------------
// Envelope transient shaper package
// Register map, configuration struct, back-end states and fixed constants.
// ----------------------------------------------------------------------------
package etsu_pkg;

    localparam int CFG_DATA_W  = 23;
    localparam int CFG_INDEX_W = 2;
    localparam int ENV_W       = 32;
    localparam int GAIN_W      = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RISE_THRESHOLD = 2'd0,
        REG_ATTACK_GAIN    = 2'd1,
        REG_SUSTAIN_GAIN   = 2'd2,
        REG_TWO_CHANNELS   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [22:0]       rise_threshold;
        logic [GAIN_W-1:0] attack_gain;
        logic [GAIN_W-1:0] sustain_gain;
        logic              two_channels;
    } cfg_t;

    localparam logic [22:0]       RISE_THRESHOLD_RST = 23'd8389;
    localparam logic [GAIN_W-1:0] ATTACK_GAIN_RST    = 16'd4096;
    localparam logic [GAIN_W-1:0] SUSTAIN_GAIN_RST   = 16'd4096;
    localparam logic              TWO_CHANNELS_RST   = 1'b1;

    // follower coefficients, Q0.16 (0.9 and 0.1)
    localparam logic [15:0] COEF_PREV  = 16'd58982;
    localparam logic [15:0] COEF_NEW   = 16'd6554;
    localparam int          ROUND_ENV  = 32768;
    localparam int          ROUND_GAIN = 2048;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ENV,
        B_GAIN,
        B_OUT
    } back_state_t;

endpackage

// ----- rtl/core/etsu_front.sv -----
// ----------------------------------------------------------------------------
// Envelope transient shaper: front end
// Accepts frames, measures their level and hands them to the queue.
// ----------------------------------------------------------------------------
module etsu_front
    import etsu_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    localparam int LEVEL_W = SAMPLE_BITS + 8,
    localparam int ITEM_W  = 3 * SAMPLE_BITS + 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_left,
    input  logic [SAMPLE_BITS-1:0] in_right,
    input  logic                   in_start,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [ITEM_W-1:0]      push_data
);

    logic                   valid_reg;
    logic [ITEM_W-1:0]      item_reg;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [SAMPLE_BITS:0]   mag_sum;
    logic [LEVEL_W-1:0]     level;

    // magnitude of the most negative sample fits unsigned
    assign mag_l   = in_left[SAMPLE_BITS-1]  ? (~in_left + SAMPLE_BITS'(1))  : in_left;
    assign mag_r   = in_right[SAMPLE_BITS-1] ? (~in_right + SAMPLE_BITS'(1)) : in_right;
    assign mag_sum = {1'b0, mag_l} + {1'b0, mag_r};

    always_comb begin
        if (cfg.two_channels) begin
            level = {mag_sum, 7'd0};
        end else begin
            level = {mag_l, 8'd0};
        end
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= {in_start, level, in_right, in_left};
        end
    end

endmodule

// ----- rtl/core/etsu_queue.sv -----
// ----------------------------------------------------------------------------
// Envelope transient shaper: frame queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module etsu_queue
    import etsu_pkg::*;
#(
    parameter int WIDTH = 81
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/etsu_back.sv -----
// ----------------------------------------------------------------------------
// Envelope transient shaper: back end
// Envelope follower, transient decision, gain and saturation, output register.
// ----------------------------------------------------------------------------
module etsu_back
    import etsu_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    localparam int LEVEL_W = SAMPLE_BITS + 8,
    localparam int ITEM_W  = 3 * SAMPLE_BITS + 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   q_valid,
    input  logic [ITEM_W-1:0]      q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_left,
    output logic [SAMPLE_BITS-1:0] out_right,
    output logic                   out_transient
);

    localparam int PP_W   = ENV_W + 16;
    localparam int PN_W   = LEVEL_W + 13;
    localparam int SUM_W  = ((PN_W > PP_W) ? PN_W : PP_W) + 1;
    localparam int MUL_W  = SAMPLE_BITS + 17;
    localparam int RND_W  = SAMPLE_BITS + 18;
    localparam int SH_W   = SAMPLE_BITS + 6;

    back_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic                          start_reg;
    logic [LEVEL_W-1:0]            level_reg;
    logic [ENV_W-1:0]              prev_reg;
    logic [PP_W-1:0]               prod_prev_reg;
    logic [PN_W-1:0]               prod_new_reg;
    logic [ENV_W-1:0]              env_reg;
    logic                          transient_reg;
    logic [GAIN_W-1:0]             gain_reg;
    logic signed [MUL_W-1:0]       mul_l_reg;
    logic signed [MUL_W-1:0]       mul_r_reg;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_left_reg;
    logic [SAMPLE_BITS-1:0]        out_right_reg;
    logic                          out_transient_reg;

    logic [ENV_W-1:0]       prev_sel;
    logic [SUM_W-1:0]       env_sum;
    logic [SUM_W-17:0]      env_full;
    logic [ENV_W-1:0]       env_new;
    logic signed [ENV_W+1:0] env_rise;
    logic signed [ENV_W+1:0] rise_limit;
    logic                   rise_hit;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] sat_l;
    logic [SAMPLE_BITS-1:0] sat_r;

    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [MUL_W-1:0] p);
        logic signed [RND_W-1:0] rnd;
        logic [SH_W-1:0]         sh;
        logic [SAMPLE_BITS-1:0]  res;
        rnd = $signed({p[MUL_W-1], p}) + $signed(RND_W'(ROUND_GAIN));
        sh  = rnd[RND_W-1:12];
        if ((&sh[SH_W-1:SAMPLE_BITS-1]) || !(|sh[SH_W-1:SAMPLE_BITS-1])) begin
            res = sh[SAMPLE_BITS-1:0];
        end else if (sh[SH_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    assign prev_sel   = start_reg ? '0 : env_reg;
    assign env_sum    = SUM_W'(prod_prev_reg) + SUM_W'(prod_new_reg) + SUM_W'(ROUND_ENV);
    assign env_full   = env_sum[SUM_W-1:16];
    assign env_new    = (|env_full[SUM_W-17:ENV_W]) ? '1 : env_full[ENV_W-1:0];
    assign env_rise   = $signed({2'b00, env_new}) - $signed({2'b00, prev_reg});
    assign rise_limit = $signed({3'b000, cfg.rise_threshold, 8'd0});
    assign rise_hit   = !start_reg && (env_rise > rise_limit);
    assign out_free   = !out_valid_reg || out_ready;
    assign sat_l      = round_sat(mul_l_reg);
    assign sat_r      = round_sat(mul_r_reg);

    assign q_pop         = (state_reg == B_IDLE) && q_valid;
    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign out_transient = out_transient_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    state_next = B_MUL;
                end
            end
            B_MUL:  state_next = B_ENV;
            B_ENV:  state_next = B_GAIN;
            B_GAIN: state_next = B_OUT;
            B_OUT: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == B_ENV) begin
                env_reg <= env_new;
            end
            if (state_reg == B_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            {start_reg, level_reg, right_reg, left_reg} <= q_data;
        end
        if (state_reg == B_MUL) begin
            prev_reg      <= prev_sel;
            prod_prev_reg <= PP_W'(COEF_PREV) * PP_W'(prev_sel);
            prod_new_reg  <= PN_W'(COEF_NEW) * PN_W'(level_reg);
        end
        if (state_reg == B_ENV) begin
            transient_reg <= rise_hit;
            gain_reg      <= rise_hit ? cfg.attack_gain : cfg.sustain_gain;
        end
        if (state_reg == B_GAIN) begin
            mul_l_reg <= MUL_W'(left_reg) * MUL_W'($signed({1'b0, gain_reg}));
            mul_r_reg <= MUL_W'(right_reg) * MUL_W'($signed({1'b0, gain_reg}));
        end
        if (state_reg == B_OUT && out_free) begin
            out_left_reg      <= start_reg ? left_reg : sat_l;
            out_right_reg     <= start_reg ? right_reg : sat_r;
            out_transient_reg <= transient_reg;
        end
    end

`include "envelope_transient_shaper_unit_macros.svh"

    `ETSU_ASSERT_NEXT(a_start_no_transient, (state_reg == B_ENV) && start_reg, !transient_reg, "block start frame flagged transient")
    `ETSU_ASSERT_NEXT(a_env_only_in_update, state_reg != B_ENV, $stable(env_reg), "envelope changed outside update step")
    `ETSU_ASSERT_NEXT(a_out_stall_holds, (state_reg == B_OUT) && !out_free, (state_reg == B_OUT) && $stable(mul_l_reg), "back end left output step while output busy")
    `ETSU_ASSERT_NOW(a_pop_idle_only, q_pop, (state_reg == B_IDLE) && !(out_valid_reg && !out_ready && state_reg == B_OUT), "queue popped outside idle")

endmodule

// ----- rtl/core/envelope_transient_shaper_unit.sv -----
// ----------------------------------------------------------------------------
// Envelope transient shaper unit
// Stereo transient shaper with one-pole envelope follower and gain stage.
// ----------------------------------------------------------------------------
// One stereo frame per transfer on s_; one shaped frame per transfer on m_.
// The front end registers each frame with its level and queues it (two deep);
// the back end processes one frame at a time (queue pop, follower multiplies,
// envelope update and transient decision, gain multiplies, output load) and
// pops the next frame only after the output load of the last; the output load
// waits while a previous shaped frame is still unaccepted on m_. The
// back end is the rate limit because each envelope depends on the previous
// one. Write configuration only while no frame is in flight: two_channels is
// applied when a frame is accepted, the other registers when it is processed.
// ----------------------------------------------------------------------------
module envelope_transient_shaper_unit
    import etsu_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // sample_left, sample_right
    input  logic                   s_tuser,   // block_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // out_left, out_right
    output logic                   m_tuser    // transient
);

    localparam int ITEM_W = 3 * SAMPLE_BITS + 9;

    cfg_t                   cfg_reg;
    logic                   push_valid;
    logic                   push_ready;
    logic [ITEM_W-1:0]      push_data;
    logic                   q_valid;
    logic                   q_pop;
    logic [ITEM_W-1:0]      q_data;
    logic [SAMPLE_BITS-1:0] out_left;
    logic [SAMPLE_BITS-1:0] out_right;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_threshold <= RISE_THRESHOLD_RST;
            cfg_reg.attack_gain    <= ATTACK_GAIN_RST;
            cfg_reg.sustain_gain   <= SUSTAIN_GAIN_RST;
            cfg_reg.two_channels   <= TWO_CHANNELS_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_RISE_THRESHOLD: cfg_reg.rise_threshold <= cfg_wdata;
                REG_ATTACK_GAIN:    cfg_reg.attack_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_SUSTAIN_GAIN:   cfg_reg.sustain_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_TWO_CHANNELS:   cfg_reg.two_channels   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    etsu_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_left    (s_tdata[SAMPLE_BITS-1:0]),
        .in_right   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_start   (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    etsu_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    etsu_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_left      (out_left),
        .out_right     (out_right),
        .out_transient (m_tuser)
    );

    assign m_tdata = TDATA_W'({out_right, out_left});

endmodule

// ----- dv/testbench.sv -----
// ============================================================================
// Envelope transient shaper unit testbench
// Streams stereo frames through the shaper and checks every shaped frame
// against an in-bench envelope follower and gain predictor. Directed frames
// cover the sample and gain extremes, buffer restarts, mono mode and register
// masking. Random buffers with loud and quiet stretches run under changing
// register settings, with random gaps on both sides and one long output stall.
// ============================================================================
module testbench
    import etsu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SAMPLE_BITS = 24;
    localparam int     TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint ENV_MAX     = 64'd4294967295;
    localparam int     RANDOM_ITEMS = 500;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t out_left;
        sample_t out_right;
        logic    transient;
    } shaped_frame_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;   // sample_left, sample_right
    logic                   s_tuser;   // block_start
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;   // out_left, out_right
    logic                   m_tuser;   // transient

    cfg_t          shaper_cfg;
    logic [31:0]   env_level;
    shaped_frame_t pending_frames[$];
    int            n_errors;
    int            frames_sent;
    int            hold_left;
    int            stall_left;
    bit            src_gaps;
    bit            sink_gaps;

    envelope_transient_shaper_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("envelope_transient_shaper_unit: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic sample_t scale_sample(sample_t s, logic [GAIN_W-1:0] g);
        longint p;
        p = s;
        p = (p * longint'(g) + ROUND_GAIN) >>> 12;
        if (p > SAMPLE_MAX) p = SAMPLE_MAX;
        if (p < SAMPLE_MIN) p = SAMPLE_MIN;
        return sample_t'(p);
    endfunction

    // follower and gain decision for one accepted frame
    function automatic void shape_frame(sample_t l, sample_t r, logic start);
        longint        mag_l;
        longint        mag_r;
        longint        level;
        longint        prev;
        longint        env;
        logic          rising;
        logic [GAIN_W-1:0] g;
        shaped_frame_t f;
        mag_l = l;
        mag_r = r;
        if (mag_l < 0) mag_l = -mag_l;
        if (mag_r < 0) mag_r = -mag_r;
        level = shaper_cfg.two_channels ? (mag_l + mag_r) << 7 : mag_l << 8;
        prev  = start ? 0 : longint'(env_level);
        env   = (longint'(COEF_PREV) * prev + longint'(COEF_NEW) * level + ROUND_ENV) >>> 16;
        if (env > ENV_MAX) env = ENV_MAX;
        env_level = env[31:0];
        if (start) begin
            f.out_left  = l;
            f.out_right = r;
            f.transient = 1'b0;
        end else begin
            rising      = (env - prev) > (longint'(shaper_cfg.rise_threshold) << 8);
            g           = rising ? shaper_cfg.attack_gain : shaper_cfg.sustain_gain;
            f.out_left  = scale_sample(l, g);
            f.out_right = scale_sample(r, g);
            f.transient = rising;
        end
        pending_frames.push_back(f);
    endfunction

    // called and returns at a falling edge
    task automatic send_frame(sample_t l, sample_t r, logic start);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 2) == 0) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tuser  <= start;
        do @(posedge aclk); while (s_tready !== 1'b1);
        shape_frame(l, r, start);
        frames_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_frames.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_frames.size() > 0) begin
            $display("%0t: %0d shaped frames never arrived", $realtime,
                     pending_frames.size());
            n_errors++;
            pending_frames.delete();
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_RISE_THRESHOLD: shaper_cfg.rise_threshold = val[22:0];
            REG_ATTACK_GAIN:    shaper_cfg.attack_gain    = val[GAIN_W-1:0];
            REG_SUSTAIN_GAIN:   shaper_cfg.sustain_gain   = val[GAIN_W-1:0];
            REG_TWO_CHANNELS:   shaper_cfg.two_channels   = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int pick_amp();
        case ($urandom_range(0, 3))
            0: return 255;
            1: return 65535;
            2: return 8388608;
            default: return 0;
        endcase
    endfunction

    function automatic sample_t any_sample(int amp);
        longint mag;
        if ($urandom_range(0, 3) == 0) return sample_t'($urandom);
        mag = $urandom_range(0, amp);
        if ($urandom_range(0, 1)) return sample_t'(-mag);
        return sample_t'(mag > SAMPLE_MAX ? SAMPLE_MAX : mag);
    endfunction

    task automatic send_buffer();
        int len;
        int amp;
        int jump_at;
        len     = $urandom_range(3, 16);
        amp     = pick_amp();
        jump_at = $urandom_range(1, len);
        send_frame(any_sample(amp), any_sample(amp), 1'b1);
        for (int i = 1; i < len; i++) begin
            if (i == jump_at) amp = pick_amp();
            send_frame(any_sample(amp), any_sample(amp), 1'b0);
        end
    endtask

    task automatic random_config();
        logic [22:0] thr;
        case ($urandom_range(0, 4))
            0: thr = '0;
            1: thr = 23'h7F_FFFF;
            2: thr = 23'($urandom_range(0, 20000));
            default: thr = 23'($urandom_range(0, 1000000));
        endcase
        write_reg(REG_RISE_THRESHOLD, thr);
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(0, 4))
                0: thr = '0;
                1: thr = 23'd4096;
                2: thr = 23'hFFFF;
                default: thr = 23'($urandom);
            endcase
            write_reg(k == 0 ? REG_ATTACK_GAIN : REG_SUSTAIN_GAIN, thr);
        end
        write_reg(REG_TWO_CHANNELS, 23'($urandom));
    endtask

    // reset values, unity gains
    task automatic test_reset_defaults();
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), 1'b1);
        send_frame('0, '0, 1'b0);
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN), 1'b0);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), 1'b0);
        send_frame('0, '0, 1'b1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), 1'b0);
        wait_idle();
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_RISE_THRESHOLD, '0);
        write_reg(REG_ATTACK_GAIN, 23'hFFFF);
        write_reg(REG_SUSTAIN_GAIN, '0);
        send_frame('0, '0, 1'b1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), 1'b0);
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX), 1'b0);
        send_frame(sample_t'(1000), sample_t'(-1000), 1'b0);
        wait_idle();
        write_reg(REG_RISE_THRESHOLD, 23'h7F_FFFF);
        write_reg(REG_SUSTAIN_GAIN, 23'd1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), 1'b0);
        send_frame(sample_t'(-1), sample_t'(1), 1'b0);
        wait_idle();
    endtask

    // upper write bits must be dropped
    task automatic test_mono_and_masking();
        write_reg(REG_RISE_THRESHOLD, 23'd100);
        write_reg(REG_ATTACK_GAIN, 23'h7F_0800);
        write_reg(REG_SUSTAIN_GAIN, 23'h40_2000);
        write_reg(REG_TWO_CHANNELS, 23'h7F_FFFE);
        send_frame('0, sample_t'(SAMPLE_MAX), 1'b1);
        send_frame('0, sample_t'(SAMPLE_MIN), 1'b0);
        send_frame(sample_t'(SAMPLE_MIN), '0, 1'b0);
        send_frame(sample_t'(-3), sample_t'(SAMPLE_MAX), 1'b0);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(-1), 1'b0);
        send_frame('0, '0, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        src_gaps = 1'b0;
        write_reg(REG_TWO_CHANNELS, 23'd1);
        write_reg(REG_RISE_THRESHOLD, 23'd2000);
        @(posedge aclk);
        hold_left = 300;
        @(negedge aclk);
        send_buffer();
        send_buffer();
        wait_idle();
    endtask

    task automatic test_random();
        int phase_start;
        while (frames_sent < RANDOM_ITEMS + 50) begin
            random_config();
            src_gaps    = $urandom_range(0, 3) != 0;
            sink_gaps   = $urandom_range(0, 3) != 0;
            phase_start = frames_sent;
            while (frames_sent - phase_start < 60) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 4))
                        send_frame(sample_t'($urandom), sample_t'($urandom), 1'($urandom));
                end else begin
                    send_buffer();
                end
            end
            wait_idle();
        end
    endtask

    // result side ready, with random stalls and the long hold
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (sink_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        shaped_frame_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected transfer, data %h transient %b",
                         $realtime, m_tdata, m_tuser);
                n_errors++;
            end else begin
                want = pending_frames.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== want.out_left) begin
                    $display("%0t: out_left expected %h actual %h", $realtime,
                             want.out_left, m_tdata[SAMPLE_BITS-1:0]);
                    n_errors++;
                end
                if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.out_right) begin
                    $display("%0t: out_right expected %h actual %h", $realtime,
                             want.out_right, m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                    n_errors++;
                end
                if (m_tuser !== want.transient) begin
                    $display("%0t: transient expected %b actual %b", $realtime,
                             want.transient, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_RISE_THRESHOLD;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        n_errors    = 0;
        frames_sent = 0;
        hold_left   = 0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        env_level   = '0;
        shaper_cfg.rise_threshold = RISE_THRESHOLD_RST;
        shaper_cfg.attack_gain    = ATTACK_GAIN_RST;
        shaper_cfg.sustain_gain   = SUSTAIN_GAIN_RST;
        shaper_cfg.two_channels   = TWO_CHANNELS_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_gain_extremes();
        test_mono_and_masking();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("envelope_transient_shaper_unit: match");
        end else begin
            $display("envelope_transient_shaper_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- envelope_transient_shaper_unit.f -----
+incdir+rtl/core
rtl/core/etsu_pkg.sv
rtl/core/etsu_front.sv
rtl/core/etsu_queue.sv
rtl/core/etsu_back.sv
rtl/core/envelope_transient_shaper_unit.sv
dv/testbench.sv
